// ===== design/indexed_array_table_engine_top_macros.svh =====
// Assertion macros used by the indexed array table engine datapath.
`ifndef INDEXED_ARRAY_TABLE_ENGINE_TOP_MACROS_SVH
`define INDEXED_ARRAY_TABLE_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define IATE_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define IATE_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/iate_pkg.sv =====
// Types and constants shared by the indexed array table engine.
`timescale 1ns / 1ps
package iate_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int WORD_W   = 32;
  localparam int KIND_W   = 3;
  localparam int POS_W    = 11;
  localparam int CNT_W    = 11;
  localparam int FOUND_W  = 10;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_READ   = 3'd1,
    KIND_WRITE  = 3'd2,
    KIND_INSERT = 3'd3,
    KIND_REMOVE = 3'd4,
    KIND_FIND   = 3'd5,
    KIND_CLEAR  = 3'd6
  } kind_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_LATCH     = 4'd1,
    OP_FAIL      = 4'd2,
    OP_APPEND    = 4'd3,
    OP_WRITE     = 4'd4,
    OP_RD_ISSUE  = 4'd5,
    OP_RD_DONE   = 4'd6,
    OP_INS_PUT   = 4'd7,
    OP_REM_DONE  = 4'd8,
    OP_CLEAR     = 4'd9,
    OP_UP_INIT   = 4'd10,
    OP_DN_INIT   = 4'd11,
    OP_SHIFT     = 4'd12,
    OP_FIND_INIT = 4'd13,
    OP_FIND_STEP = 4'd14,
    OP_FIND_HIT  = 4'd15
  } dp_op_t;

  // Status from datapath to controller.
  typedef struct packed {
    kind_t kind;
    logic  rd_ok;       // position < count
    logic  app_ok;      // count < capacity
    logic  ins_ok;      // position <= count and not full
    logic  ins_direct;  // insert at the end, nothing to move
    logic  rem_direct;  // remove of the last entry, nothing to move
    logic  empty;
    logic  shift_last;  // final read of a move
    logic  find_last;   // final read of a search
    logic  hit;         // compared word matches
    logic  out_free;    // result register can take a beat
  } sts_t;

endpackage

// ===== design/iate_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module iate_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/iate_ctrl.sv =====
// Controller state machine of the indexed array table engine.
`timescale 1ns / 1ps
module iate_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  iate_pkg::sts_t  sts,
  output iate_pkg::dp_op_t op
);

  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_DISPATCH  = 9'b000000010,
    ST_READ_WAIT = 9'b000000100,
    ST_SHIFT     = 9'b000001000,
    ST_DRAIN     = 9'b000010000,
    ST_INS_END   = 9'b000100000,
    ST_REM_END   = 9'b001000000,
    ST_FIND      = 9'b010000000,
    ST_FIND_END  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    op        = iate_pkg::OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op        = iate_pkg::OP_LATCH;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        // hold until the result register is free, so a finish never overwrites
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
          unique case (sts.kind)
            iate_pkg::KIND_APPEND: begin
              op = sts.app_ok ? iate_pkg::OP_APPEND : iate_pkg::OP_FAIL;
            end
            iate_pkg::KIND_READ: begin
              if (sts.rd_ok) begin
                op        = iate_pkg::OP_RD_ISSUE;
                state_nxt = ST_READ_WAIT;
              end else begin
                op = iate_pkg::OP_FAIL;
              end
            end
            iate_pkg::KIND_WRITE: begin
              op = sts.rd_ok ? iate_pkg::OP_WRITE : iate_pkg::OP_FAIL;
            end
            iate_pkg::KIND_INSERT: begin
              if (!sts.ins_ok) begin
                op = iate_pkg::OP_FAIL;
              end else if (sts.ins_direct) begin
                op = iate_pkg::OP_INS_PUT;
              end else begin
                op        = iate_pkg::OP_UP_INIT;
                state_nxt = ST_SHIFT;
              end
            end
            iate_pkg::KIND_REMOVE: begin
              if (!sts.rd_ok) begin
                op = iate_pkg::OP_FAIL;
              end else if (sts.rem_direct) begin
                op = iate_pkg::OP_REM_DONE;
              end else begin
                op        = iate_pkg::OP_DN_INIT;
                state_nxt = ST_SHIFT;
              end
            end
            iate_pkg::KIND_FIND: begin
              if (sts.empty) begin
                op = iate_pkg::OP_FAIL;
              end else begin
                op        = iate_pkg::OP_FIND_INIT;
                state_nxt = ST_FIND;
              end
            end
            iate_pkg::KIND_CLEAR: begin
              op = iate_pkg::OP_CLEAR;
            end
            default: begin
              op = iate_pkg::OP_FAIL;
            end
          endcase
        end
      end
      ST_READ_WAIT: begin
        op        = iate_pkg::OP_RD_DONE;
        state_nxt = ST_IDLE;
      end
      ST_SHIFT: begin
        op = iate_pkg::OP_SHIFT;
        if (sts.shift_last) begin
          state_nxt = (sts.kind == iate_pkg::KIND_INSERT) ? ST_DRAIN : ST_REM_END;
        end
      end
      ST_DRAIN: begin
        // last moved word lands this cycle; write port busy
        state_nxt = ST_INS_END;
      end
      ST_INS_END: begin
        op        = iate_pkg::OP_INS_PUT;
        state_nxt = ST_IDLE;
      end
      ST_REM_END: begin
        op        = iate_pkg::OP_REM_DONE;
        state_nxt = ST_IDLE;
      end
      ST_FIND: begin
        if (sts.hit) begin
          op        = iate_pkg::OP_FIND_HIT;
          state_nxt = ST_IDLE;
        end else begin
          op = iate_pkg::OP_FIND_STEP;
          if (sts.find_last) begin
            state_nxt = ST_FIND_END;
          end
        end
      end
      ST_FIND_END: begin
        op        = sts.hit ? iate_pkg::OP_FIND_HIT : iate_pkg::OP_FAIL;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/iate_dp.sv =====
// Datapath: request registers, fill count, entry RAM, walk index, result register.
`timescale 1ns / 1ps
`include "indexed_array_table_engine_top_macros.svh"
module iate_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [iate_pkg::KIND_W-1:0]         in_kind,
  input  logic [iate_pkg::POS_W-1:0]          in_position,
  input  logic signed [iate_pkg::WORD_W-1:0]  in_word,
  input  iate_pkg::dp_op_t                    op,
  output iate_pkg::sts_t                      sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_ok,
  output logic signed [iate_pkg::WORD_W-1:0]  out_read_word,
  output logic [iate_pkg::FOUND_W-1:0]        out_found_at,
  output logic [iate_pkg::CNT_W-1:0]          out_fill_count
);

  localparam int AW = iate_pkg::ADDR_W;
  localparam int CW = iate_pkg::CNT_W;
  localparam int WW = iate_pkg::WORD_W;

  iate_pkg::kind_t          kind_r;
  logic [iate_pkg::POS_W-1:0] pos_r;
  logic [WW-1:0]            word_r;
  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic                     pend_r;
  logic [AW-1:0]            pend_addr_r, pend_addr_nxt;
  logic                     cmp_v_r;
  logic [AW-1:0]            cmp_idx_r;
  logic                     out_valid_r;
  logic                     res_ok_r;
  logic [WW-1:0]            res_rd_r;
  logic [AW-1:0]            res_at_r;
  logic [CW-1:0]            res_fill_r;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [WW-1:0]            ram_wdata, rdata;

  logic                     ins_dir;
  logic                     fin;
  logic                     cmd_wr;
  logic [CW:0]              pos_inc_w;
  logic [CW-1:0]            cnt_dec_w;
  logic [CW-1:0]            idx_ext_w;

  assign ins_dir   = (kind_r == iate_pkg::KIND_INSERT);
  assign pos_inc_w = {1'b0, pos_r} + {{CW{1'b0}}, 1'b1};
  assign cnt_dec_w = count_r - iate_pkg::CNT_ONE;
  assign idx_ext_w = CW'(idx_r);

  assign cmd_wr = (op == iate_pkg::OP_APPEND) || (op == iate_pkg::OP_WRITE) ||
                  (op == iate_pkg::OP_INS_PUT);
  assign fin    = cmd_wr || (op == iate_pkg::OP_FAIL) || (op == iate_pkg::OP_RD_DONE) ||
                  (op == iate_pkg::OP_REM_DONE) || (op == iate_pkg::OP_CLEAR) ||
                  (op == iate_pkg::OP_FIND_HIT);

  // request registers
  always_ff @(posedge clk) begin
    if (op == iate_pkg::OP_LATCH) begin
      kind_r <= iate_pkg::kind_t'(in_kind);
      pos_r  <= in_position;
      word_r <= in_word;
    end
  end

  // fill count and walk index
  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    case (op) inside
      iate_pkg::OP_APPEND,
      iate_pkg::OP_INS_PUT:   count_nxt = count_r + iate_pkg::CNT_ONE;
      iate_pkg::OP_REM_DONE:  count_nxt = cnt_dec_w;
      iate_pkg::OP_CLEAR:     count_nxt = '0;
      iate_pkg::OP_UP_INIT:   idx_nxt   = cnt_dec_w[AW-1:0];
      iate_pkg::OP_DN_INIT:   idx_nxt   = pos_inc_w[AW-1:0];
      iate_pkg::OP_FIND_INIT: idx_nxt   = '0;
      iate_pkg::OP_SHIFT:     idx_nxt   = ins_dir ? idx_r - AW'(1) : idx_r + AW'(1);
      iate_pkg::OP_FIND_STEP: idx_nxt   = idx_r + AW'(1);
      default: ;
    endcase
  end

  assign pend_addr_nxt = ins_dir ? idx_r + AW'(1) : idx_r - AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= (op == iate_pkg::OP_SHIFT);
      cmp_v_r     <= (op == iate_pkg::OP_FIND_STEP);
      out_valid_r <= fin ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pend_addr_r <= pend_addr_nxt;
    cmp_idx_r   <= idx_r;
    if (fin) begin
      res_ok_r   <= (op != iate_pkg::OP_FAIL);
      res_rd_r   <= (op == iate_pkg::OP_RD_DONE) ? rdata : '0;
      res_at_r   <= (op == iate_pkg::OP_FIND_HIT) ? cmp_idx_r : '0;
      res_fill_r <= count_nxt;
    end
  end

  // RAM ports: a moved word is written the cycle after its read
  assign ram_re    = (op == iate_pkg::OP_RD_ISSUE) || (op == iate_pkg::OP_SHIFT) ||
                     (op == iate_pkg::OP_FIND_STEP);
  assign ram_raddr = (op == iate_pkg::OP_RD_ISSUE) ? pos_r[AW-1:0] : idx_r;
  assign ram_we    = pend_r || cmd_wr;
  assign ram_waddr = pend_r ? pend_addr_r :
                     ((op == iate_pkg::OP_APPEND) ? count_r[AW-1:0] : pos_r[AW-1:0]);
  assign ram_wdata = pend_r ? rdata : word_r;

  iate_ram #(
    .WIDTH (WW),
    .DEPTH (iate_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // status
  assign sts.kind       = kind_r;
  assign sts.rd_ok      = (pos_r < count_r);
  assign sts.app_ok     = (count_r < iate_pkg::CAP_CNT);
  assign sts.ins_ok     = (pos_r <= count_r) && (count_r < iate_pkg::CAP_CNT);
  assign sts.ins_direct = (pos_r == count_r);
  assign sts.rem_direct = (pos_inc_w >= {1'b0, count_r});
  assign sts.empty      = (count_r == '0);
  assign sts.find_last  = ((idx_ext_w + iate_pkg::CNT_ONE) == count_r);
  assign sts.shift_last = ins_dir ? (idx_ext_w == pos_r) : sts.find_last;
  assign sts.hit        = cmp_v_r && (rdata == word_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_ok         = res_ok_r;
  assign out_read_word  = res_rd_r;
  assign out_found_at   = iate_pkg::FOUND_W'(res_at_r);
  assign out_fill_count = res_fill_r;

  `IATE_CHECK(a_fin_slot_free, fin, !out_valid_r || out_ready, "result overwritten")
  `IATE_CHECK(a_wr_port_clash, pend_r, !cmd_wr, "move write clashes with command write")
  `IATE_CHECK(a_count_bound, 1'b1, count_r <= iate_pkg::CAP_CNT, "fill count past capacity")
  `IATE_CHECK(a_hit_needs_cmp, op == iate_pkg::OP_FIND_HIT, cmp_v_r, "hit without compare")
  `IATE_CHECK_NEXT(a_move_lands, op == iate_pkg::OP_SHIFT,
                   ram_we && (ram_waddr == $past(pend_addr_nxt)), "moved word misplaced")

endmodule

// ===== design/indexed_array_table_engine_top.sv =====
// Top level of the indexed array table engine: controller plus datapath.
// Throughput: one request in flight; insert, remove and find move one entry per cycle
//   through the single RAM write port and single read port.
// Reset (rst_n low, synchronous): fill count zero, result empty, controller idle, RAM kept.
`timescale 1ns / 1ps
module indexed_array_table_engine_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [iate_pkg::KIND_W-1:0]         in_kind,
  input  logic [iate_pkg::POS_W-1:0]          in_position,
  input  logic signed [iate_pkg::WORD_W-1:0]  in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_ok,
  output logic signed [iate_pkg::WORD_W-1:0]  out_read_word,
  output logic [iate_pkg::FOUND_W-1:0]        out_found_at,
  output logic [iate_pkg::CNT_W-1:0]          out_fill_count
);

  // command from controller, status back from datapath
  iate_pkg::dp_op_t op;
  iate_pkg::sts_t   sts;

  // The controller takes an input beat only when idle; it then waits in
  // dispatch until the result register is free, so a finished beat may sit
  // on the output while the next request is already taken in.
  iate_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .op       (op)
  );

  // The datapath holds the request, the fill count, the entry RAM and the
  // result register. Moves read one entry a cycle and write it in the cycle
  // after, one place up (insert) or down (remove); find compares one
  // registered read a cycle and stops on the first match.
  iate_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_kind        (in_kind),
    .in_position    (in_position),
    .in_word        (in_word),
    .op             (op),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_read_word  (out_read_word),
    .out_found_at   (out_found_at),
    .out_fill_count (out_fill_count)
  );

endmodule
